// ===== src/skat_pkg.sv =====
`default_nettype none

package skat_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int NAME_LEN    = 64;

    localparam int SLOT_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int BYTE_W      = $clog2(NAME_LEN);
    localparam int LEN_W       = $clog2(NAME_LEN + 2);
    localparam int NAMES_DEPTH = MAX_ENTRIES * NAME_LEN;
    localparam int NADDR_W     = $clog2(NAMES_DEPTH);

    localparam int CHAR_W      = 8;
    localparam int NUM_W       = 50;
    localparam int IDX_W       = 6;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_ADDED   = 3'd0,
        ST_FOUND   = 3'd1,
        ST_MISS    = 3'd2,
        ST_FULL    = 3'd3,
        ST_LONG    = 3'd4,
        ST_CLEARED = 3'd5
    } status_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [CHAR_W-1:0] name_char;
        logic              name_last;
        logic [NUM_W-1:0]  phone_number;
    } in_item_t;

    typedef struct packed {
        status_t           status;
        logic [NUM_W-1:0]  found_number;
        logic [IDX_W-1:0]  entry_index;
    } out_item_t;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_SLOT,
        SCAN_LEN,
        SCAN_BYTE,
        SCAN_NUM
    } scan_state_t;

    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] key_len;
        logic [CNT_W-1:0] count;
    } scan_cmd_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot_addr;
        logic [BYTE_W-1:0]  key_addr;
        logic [NADDR_W-1:0] name_addr;
    } scan_addr_t;

    typedef struct packed {
        logic              done;
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } scan_res_t;

    // row base of a slot plus the byte offset within the row
    function automatic logic [NADDR_W-1:0] name_addr_f(
        input logic [SLOT_W-1:0] slot,
        input logic [BYTE_W-1:0] offs
    );
        logic [NADDR_W-1:0] base;
        base = NADDR_W'(NADDR_W'(slot) * NADDR_W'(NAME_LEN));
        return base + NADDR_W'(offs);
    endfunction

endpackage

`default_nettype wire

// ===== src/skat_ram.sv =====
`default_nettype none

module skat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== src/skat_scan.sv =====
`default_nettype none

module skat_scan (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire skat_pkg::scan_cmd_t           cmd,
    input  wire logic [skat_pkg::LEN_W-1:0]    len_rd_data,
    input  wire logic [skat_pkg::CHAR_W-1:0]   key_rd_data,
    input  wire logic [skat_pkg::CHAR_W-1:0]   name_rd_data,
    output skat_pkg::scan_addr_t               rd_addr,
    output skat_pkg::scan_res_t                res,
    output logic                               busy
);

    localparam int LEN_W  = skat_pkg::LEN_W;
    localparam int CNT_W  = skat_pkg::CNT_W;
    localparam int BYTE_W = skat_pkg::BYTE_W;
    localparam int SLOT_W = skat_pkg::SLOT_W;

    skat_pkg::scan_state_t state_reg, state_next;
    logic [CNT_W-1:0]  slot_reg, slot_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic [LEN_W-1:0]  klen_reg, klen_next;

    logic slot_end;
    logic len_eq;
    logic byte_eq;
    logic byte_last;

    assign slot_end  = (slot_reg == cnt_reg);
    assign len_eq    = (len_rd_data == klen_reg);
    assign byte_eq   = (key_rd_data == name_rd_data);
    assign byte_last = ((LEN_W'(byte_reg) + LEN_W'(1)) == klen_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= skat_pkg::SCAN_IDLE;
        end else begin
            state_reg <= state_next;
        end
        slot_reg <= slot_next;
        cnt_reg  <= cnt_next;
        byte_reg <= byte_next;
        klen_reg <= klen_next;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            skat_pkg::SCAN_IDLE: begin
                if (cmd.start) begin
                    state_next = skat_pkg::SCAN_SLOT;
                end
            end
            skat_pkg::SCAN_SLOT: begin
                state_next = slot_end ? skat_pkg::SCAN_IDLE : skat_pkg::SCAN_LEN;
            end
            skat_pkg::SCAN_LEN: begin
                state_next = len_eq ? skat_pkg::SCAN_BYTE : skat_pkg::SCAN_SLOT;
            end
            skat_pkg::SCAN_BYTE: begin
                if (!byte_eq) begin
                    state_next = skat_pkg::SCAN_SLOT;
                end else if (byte_last) begin
                    state_next = skat_pkg::SCAN_NUM;
                end
            end
            skat_pkg::SCAN_NUM: begin
                state_next = skat_pkg::SCAN_IDLE;
            end
            default: begin
                state_next = skat_pkg::SCAN_IDLE;
            end
        endcase
    end

    // slot and byte indices also steer the read addresses: the next-state values address the registered reads
    always_comb begin
        slot_next = slot_reg;
        cnt_next  = cnt_reg;
        byte_next = byte_reg;
        klen_next = klen_reg;
        res       = '0;
        unique case (state_reg)
            skat_pkg::SCAN_IDLE: begin
                if (cmd.start) begin
                    slot_next = '0;
                    cnt_next  = cmd.count;
                    klen_next = cmd.key_len;
                end
            end
            skat_pkg::SCAN_SLOT: begin
                if (slot_end) begin
                    res.done = 1'b1;
                end
            end
            skat_pkg::SCAN_LEN: begin
                if (len_eq) begin
                    byte_next = '0;
                end else begin
                    slot_next = slot_reg + CNT_W'(1);
                end
            end
            skat_pkg::SCAN_BYTE: begin
                if (!byte_eq) begin
                    slot_next = slot_reg + CNT_W'(1);
                end else if (!byte_last) begin
                    byte_next = byte_reg + BYTE_W'(1);
                end
            end
            skat_pkg::SCAN_NUM: begin
                res.done = 1'b1;
                res.hit  = 1'b1;
                res.slot = slot_reg[SLOT_W-1:0];
            end
            default: begin
            end
        endcase
    end

    assign rd_addr.slot_addr = slot_next[SLOT_W-1:0];
    assign rd_addr.key_addr  = byte_next;
    assign rd_addr.name_addr = skat_pkg::name_addr_f(slot_next[SLOT_W-1:0], byte_next);
    assign busy = (state_reg != skat_pkg::SCAN_IDLE);

`ifndef SYNTH
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> (state_reg == skat_pkg::SCAN_IDLE))
        else $error("scan started while busy");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        res.done |=> (state_reg == skat_pkg::SCAN_IDLE))
        else $error("scan did not return to idle after done");

    a_hit_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == skat_pkg::SCAN_NUM) |-> (slot_reg < cnt_reg))
        else $error("match reported beyond the filled slots");

    a_byte_in_key: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == skat_pkg::SCAN_BYTE) |-> (LEN_W'(byte_reg) < klen_reg))
        else $error("byte compare beyond key length");
`endif

endmodule

`default_nettype wire

// ===== src/string_key_append_table.sv =====
// Append-only table of byte-string keys, each with a 50-bit number.
// Input channel s_valid/s_ready/s_item carries one name byte per transaction;
// name_last marks the final byte and the cmd on that byte selects add or lookup.
// Clear acts on any transaction. Result channel m_valid/m_ready/m_item carries
// at most one result per input transaction.
// Name bytes are taken one per cycle while s_ready is high. Add, clear, overlong
// and full results appear in the cycle after their transaction. A lookup scans
// slots in insertion order through one byte comparator and the registered memory
// reads: a slot of equal length to the key has its bytes compared one at a time
// until one differs or the last matches; a miss follows the last slot, a hit
// fetches the number, and s_ready stays low for the whole scan. Reset empties
// the table and the key buffer at once; stored entries are only read below the
// fill count, so no clearing pass is needed. One output register holds the
// result; outside a scan a new transaction is taken while it is empty or being
// drained, so a stalled receiver stalls the input channel.
`default_nettype none

module string_key_append_table (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire skat_pkg::in_item_t  s_item,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output skat_pkg::out_item_t      m_item
);

    localparam int LEN_W       = skat_pkg::LEN_W;
    localparam int CNT_W       = skat_pkg::CNT_W;
    localparam int BYTE_W      = skat_pkg::BYTE_W;
    localparam int SLOT_W      = skat_pkg::SLOT_W;
    localparam int IDX_W       = skat_pkg::IDX_W;
    localparam int CHAR_W      = skat_pkg::CHAR_W;
    localparam int NUM_W       = skat_pkg::NUM_W;

    logic [LEN_W-1:0] key_len_reg, key_len_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg, m_valid_next;
    skat_pkg::out_item_t out_reg, out_next;

    logic accept;
    logic busy;
    logic has_room;
    logic key_fits;
    logic [LEN_W-1:0] len_inc;

    logic key_we;
    logic name_we;
    logic meta_we;
    logic res_load;
    skat_pkg::out_item_t res_item;

    skat_pkg::scan_cmd_t  scan_cmd;
    skat_pkg::scan_addr_t scan_addr;
    skat_pkg::scan_res_t  scan_res;

    logic [LEN_W-1:0]  len_rd_data;
    logic [CHAR_W-1:0] key_rd_data;
    logic [CHAR_W-1:0] name_rd_data;
    logic [NUM_W-1:0]  num_rd_data;

    assign s_ready  = !busy && (!m_valid_reg || m_ready);
    assign accept   = s_valid && s_ready;
    assign has_room = (count_reg < CNT_W'(skat_pkg::MAX_ENTRIES));
    assign key_fits = (key_len_reg < LEN_W'(skat_pkg::NAME_LEN));
    // saturate one past the limit to mark an overlong name
    assign len_inc  = (key_len_reg <= LEN_W'(skat_pkg::NAME_LEN)) ?
                      key_len_reg + LEN_W'(1) : key_len_reg;

    always_comb begin
        key_len_next     = key_len_reg;
        count_next       = count_reg;
        key_we           = 1'b0;
        name_we          = 1'b0;
        meta_we          = 1'b0;
        res_load         = 1'b0;
        res_item         = '0;
        scan_cmd.start   = 1'b0;
        scan_cmd.key_len = len_inc;
        scan_cmd.count   = count_reg;
        if (accept) begin
            unique case (s_item.cmd) inside
                skat_pkg::CMD_CLEAR: begin
                    count_next      = '0;
                    key_len_next    = '0;
                    res_load        = 1'b1;
                    res_item.status = skat_pkg::ST_CLEARED;
                end
                skat_pkg::CMD_ADD, skat_pkg::CMD_LOOKUP: begin
                    // stream the byte into the free row too, so an add needs no copy
                    key_we       = key_fits;
                    name_we      = key_fits && has_room;
                    key_len_next = len_inc;
                    if (s_item.name_last) begin
                        key_len_next = '0;
                        if (len_inc > LEN_W'(skat_pkg::NAME_LEN)) begin
                            res_load        = 1'b1;
                            res_item.status = skat_pkg::ST_LONG;
                        end else if (s_item.cmd == skat_pkg::CMD_ADD) begin
                            res_load = 1'b1;
                            if (!has_room) begin
                                res_item.status = skat_pkg::ST_FULL;
                            end else begin
                                meta_we              = 1'b1;
                                count_next           = count_reg + CNT_W'(1);
                                res_item.status      = skat_pkg::ST_ADDED;
                                res_item.entry_index = IDX_W'(count_reg);
                            end
                        end else begin
                            scan_cmd.start = 1'b1;
                        end
                    end
                end
                skat_pkg::CMD_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_load) begin
            out_next     = res_item;
            m_valid_next = 1'b1;
        end else if (scan_res.done) begin
            m_valid_next = 1'b1;
            if (scan_res.hit) begin
                out_next.status       = skat_pkg::ST_FOUND;
                out_next.found_number = num_rd_data;
                out_next.entry_index  = IDX_W'(scan_res.slot);
            end else begin
                out_next.status       = skat_pkg::ST_MISS;
                out_next.found_number = '0;
                out_next.entry_index  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_len_reg <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            key_len_reg <= key_len_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        out_reg <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

    skat_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (skat_pkg::NAME_LEN)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (key_we),
        .wr_addr (key_len_reg[BYTE_W-1:0]),
        .wr_data (s_item.name_char),
        .rd_addr (scan_addr.key_addr),
        .rd_data (key_rd_data)
    );

    skat_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (skat_pkg::NAMES_DEPTH)
    ) u_name_ram (
        .aclk    (aclk),
        .wr_en   (name_we),
        .wr_addr (skat_pkg::name_addr_f(count_reg[SLOT_W-1:0], key_len_reg[BYTE_W-1:0])),
        .wr_data (s_item.name_char),
        .rd_addr (scan_addr.name_addr),
        .rd_data (name_rd_data)
    );

    skat_ram #(
        .WIDTH (LEN_W),
        .DEPTH (skat_pkg::MAX_ENTRIES)
    ) u_len_ram (
        .aclk    (aclk),
        .wr_en   (meta_we),
        .wr_addr (count_reg[SLOT_W-1:0]),
        .wr_data (len_inc),
        .rd_addr (scan_addr.slot_addr),
        .rd_data (len_rd_data)
    );

    skat_ram #(
        .WIDTH (NUM_W),
        .DEPTH (skat_pkg::MAX_ENTRIES)
    ) u_num_ram (
        .aclk    (aclk),
        .wr_en   (meta_we),
        .wr_addr (count_reg[SLOT_W-1:0]),
        .wr_data (s_item.phone_number),
        .rd_addr (scan_addr.slot_addr),
        .rd_data (num_rd_data)
    );

    skat_scan u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (scan_cmd),
        .len_rd_data  (len_rd_data),
        .key_rd_data  (key_rd_data),
        .name_rd_data (name_rd_data),
        .rd_addr      (scan_addr),
        .res          (scan_res),
        .busy         (busy)
    );

endmodule

`default_nettype wire
